// ===== rtl/dups_pkg.sv =====
`default_nettype none

package dups_pkg;

    // Field and register widths
    localparam int MAX_THREADS_DEF = 16;
    localparam int REQ_W           = 2;
    localparam int RND_W           = 16;
    localparam int CFG_W           = 8;
    localparam int CFG_ADDR_W      = 2;
    localparam int USAGE_W         = 8;
    localparam int PRIO_W          = 8;
    localparam int OUT_IDX_W       = 4;
    localparam int OUT_W           = 8;

    // Scheduling constants
    localparam int USAGE_CHARGE    = 2;
    localparam int PRIO_OFFSET     = 4;

    // Register reset values
    localparam logic [CFG_W-1:0] MAX_USAGE_RST  = 8'd127;
    localparam logic [CFG_W-1:0] MAX_PRIO_RST   = 8'd31;
    localparam logic [CFG_W-1:0] MIN_PRIO_RST   = 8'd0;
    localparam logic [CFG_W-1:0] BASE_PRIO_RST  = 8'd4;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SLEEP    = 2'd3
    } t_status;

    typedef enum logic [REQ_W-1:0] {
        REQ_SCHED  = 2'd0,
        REQ_CREATE = 2'd1,
        REQ_SLEEP  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_USAGE = 2'd0,
        CFG_MAX_PRIO  = 2'd1,
        CFG_MIN_PRIO  = 2'd2,
        CFG_BASE_PRIO = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_WDRAIN,
        S_DIVGO,
        S_DIV,
        S_SEEK,
        S_SDRAIN,
        S_PICK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] max_usage;
        logic [CFG_W-1:0] max_prio;
        logic [CFG_W-1:0] min_prio;
        logic [CFG_W-1:0] base_prio;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/dups_mod.sv =====
`default_nettype none

module dups_mod #(
    parameter int DW = 16,
    parameter int VW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [VW-1:0]      o_rem
);

    localparam int SW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic [VW-1:0] n_rem;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[DW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_diff[VW-1:0];
        end else begin
            n_rem = w_trial[VW-1:0];
        end
    end

    // Step one bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(DW);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/dups_calc.sv =====
`default_nettype none

module dups_calc (
    input  wire dups_pkg::t_cfg                          i_cfg,
    input  wire logic [dups_pkg::USAGE_W-1:0]            i_usage,
    input  wire logic                                    i_is_cur,
    output logic [dups_pkg::USAGE_W-1:0]                 o_usage,
    output logic [dups_pkg::PRIO_W-1:0]                  o_prio
);

    import dups_pkg::*;

    logic [USAGE_W:0]   w_sum;
    logic [USAGE_W-1:0] w_charged;
    logic [USAGE_W-1:0] w_decayed;
    logic [PRIO_W-1:0]  w_raw;

    always_comb begin
        // Charge the running thread, saturating at the limit
        w_sum = {1'b0, i_usage} + (USAGE_W + 1)'(USAGE_CHARGE);
        if (!i_is_cur) begin
            w_charged = i_usage;
        end else if (w_sum > {1'b0, i_cfg.max_usage}) begin
            w_charged = i_cfg.max_usage;
        end else begin
            w_charged = w_sum[USAGE_W-1:0];
        end

        // Decay by one, floor at zero
        if (w_charged != '0) begin
            w_decayed = w_charged - USAGE_W'(1);
        end else begin
            w_decayed = '0;
        end

        // Priority from usage, then clamp to max_prio; below min_prio it is zero
        w_raw = PRIO_W'(PRIO_OFFSET) + PRIO_W'(w_decayed[USAGE_W-1:2]);
        if (w_raw < i_cfg.min_prio) begin
            o_prio = '0;
        end else if (w_raw > i_cfg.max_prio) begin
            o_prio = i_cfg.max_prio;
        end else begin
            o_prio = w_raw;
        end
        o_usage = w_decayed;
    end

endmodule

`default_nettype wire

// ===== rtl/decay_usage_priority_scheduler.sv =====
`default_nettype none
// Decay-usage thread scheduler over a table of MAX_THREADS slots (slot 0 is main).
// Input stream: tuser carries the request kind (schedule, create, sleep),
// tdata the 16-bit random value used to break priority ties.
// Output stream: one beat per request with the thread index, the switched flag
// and the table-full status.
// Config port: write enable, register index and 8-bit data; write only while idle.
// Create, sleep and the unused code are handled in the accepting cycle and the result
// is then registered at the output. Schedule steps are: accept, charge, decay and
// reprioritize every used slot (slot 0 keeps its priority), start the remainder unit
// and wait for the remainder, find the chosen slot, mark it and register the result;
// with no eligible slot the remainder and the search are skipped. The slot tables have
// one read and one write port, so the walks visit one slot per cycle, and the tie
// remainder is worked out one bit a cycle. One request is in flight at a time; tready
// is high only in idle.
// Reset restores the register defaults and a setup pass puts the main
// thread into slot 0 before the first request is taken.
// A stalled output beat holds; the next request may be accepted meanwhile and
// its result waits until the output register frees.

module decay_usage_priority_scheduler #(
    parameter int MAX_THREADS = dups_pkg::MAX_THREADS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [dups_pkg::RND_W-1:0]       i_s_axis_tdata,  // [15:0] tie_random
    input  wire logic [dups_pkg::REQ_W-1:0]       i_s_axis_tuser,  // [1:0] req_type
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [3:0] thread_index, [4] switched, [5] status, [7:6] zero
    output logic [dups_pkg::OUT_W-1:0]            o_m_axis_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [dups_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [dups_pkg::CFG_W-1:0]       i_cfg_wdata
);

    import dups_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    // Slot tables
    logic [USAGE_W-1:0] mem_usage  [MAX_THREADS];
    logic [PRIO_W-1:0]  mem_prio   [MAX_THREADS];
    t_status            mem_status [MAX_THREADS];

    t_cfg r_cfg;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_cur, n_cur;
    logic          r_out_valid, n_out_valid;
    logic          r_pv, n_pv;
    logic          r_any, n_any;

    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic [PRIO_W-1:0] r_best, n_best;
    logic [IW-1:0]     r_ties, n_ties;
    logic [IW-1:0]     r_pick, n_pick;
    logic [IW-1:0]     r_seen, n_seen;
    logic [IW-1:0]     r_sel, n_sel;
    logic [IW-1:0]     r_res_idx, n_res_idx;
    logic              r_res_sw, n_res_sw;
    logic              r_res_st, n_res_st;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    logic [USAGE_W-1:0] r_rd_usage;
    logic [PRIO_W-1:0]  r_rd_prio;
    t_status            r_rd_status;

    logic               w_we_usage, w_we_prio, w_we_status;
    logic [IW-1:0]      w_waddr;
    logic [USAGE_W-1:0] w_wusage;
    logic [PRIO_W-1:0]  w_wprio;
    t_status            w_wstatus;

    logic               w_in_acc;
    logic               w_last;
    logic               w_is_cur;
    logic [USAGE_W-1:0] w_new_usage;
    logic [PRIO_W-1:0]  w_new_prio;
    t_status            w_new_status;
    logic               w_elig;
    logic               w_hit;
    logic               w_div_start;
    logic               w_div_done;
    logic [IW-1:0]      w_div_rem;
    logic [IW+3:0]      w_idx_ext;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_usage <= MAX_USAGE_RST;
            r_cfg.max_prio  <= MAX_PRIO_RST;
            r_cfg.min_prio  <= MIN_PRIO_RST;
            r_cfg.base_prio <= BASE_PRIO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAX_USAGE: r_cfg.max_usage <= i_cfg_wdata;
                CFG_MAX_PRIO:  r_cfg.max_prio  <= i_cfg_wdata;
                CFG_MIN_PRIO:  r_cfg.min_prio  <= i_cfg_wdata;
                CFG_BASE_PRIO: r_cfg.base_prio <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Per-slot usage and priority update
    dups_calc u_calc (
        .i_cfg    (r_cfg),
        .i_usage  (r_rd_usage),
        .i_is_cur (w_is_cur),
        .o_usage  (w_new_usage),
        .o_prio   (w_new_prio)
    );

    // Tie remainder unit
    dups_mod #(
        .DW (RND_W),
        .VW (IW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_ties),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last   = (CW'(r_idx) + CW'(1)) == r_count;
    assign w_is_cur = (r_pidx == r_cur);
    assign w_elig   = (r_pidx != '0) && (w_new_status == ST_RUNNABLE);
    assign w_hit    = (r_rd_status == ST_RUNNABLE) && (r_rd_prio == r_best);
    assign w_idx_ext = {4'b0, r_res_idx};

    always_comb begin
        if (w_is_cur && r_rd_status != ST_SLEEP) begin
            w_new_status = ST_RUNNABLE;
        end else begin
            w_new_status = r_rd_status;
        end
    end

    // Sequencer: next state, table writes and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_pv        = r_pv;
        n_any       = r_any;
        n_rnd       = r_rnd;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_best      = r_best;
        n_ties      = r_ties;
        n_pick      = r_pick;
        n_seen      = r_seen;
        n_sel       = r_sel;
        n_res_idx   = r_res_idx;
        n_res_sw    = r_res_sw;
        n_res_st    = r_res_st;
        n_out_data  = r_out_data;

        w_we_usage  = 1'b0;
        w_we_prio   = 1'b0;
        w_we_status = 1'b0;
        w_waddr     = '0;
        w_wusage    = '0;
        w_wprio     = r_cfg.base_prio;
        w_wstatus   = ST_RUNNABLE;
        w_div_start = 1'b0;

        // Drop the output beat once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                w_we_usage  = 1'b1;
                w_we_status = 1'b1;
                n_state     = S_IDLE;
            end

            S_IDLE: begin
                if (w_in_acc) begin
                    n_rnd     = i_s_axis_tdata;
                    n_res_sw  = 1'b0;
                    n_res_st  = 1'b0;
                    n_res_idx = r_cur;
                    n_state   = S_FIN;
                    case (t_req'(i_s_axis_tuser))
                        REQ_SCHED: begin
                            n_idx   = '0;
                            n_pv    = 1'b0;
                            n_any   = 1'b0;
                            n_state = S_WALK;
                        end
                        REQ_CREATE: begin
                            if (r_count == CW'(MAX_THREADS)) begin
                                n_res_idx = '0;
                                n_res_st  = 1'b1;
                            end else begin
                                w_we_usage  = 1'b1;
                                w_we_prio   = 1'b1;
                                w_we_status = 1'b1;
                                w_waddr     = IW'(r_count);
                                n_count     = r_count + CW'(1);
                                n_res_idx   = IW'(r_count);
                            end
                        end
                        REQ_SLEEP: begin
                            w_we_status = 1'b1;
                            w_waddr     = r_cur;
                            w_wstatus   = ST_SLEEP;
                        end
                        REQ_NONE: ;
                        default: ;
                    endcase
                end
            end

            // Charge and decay every used slot, reprioritize all but slot 0; track best
            S_WALK, S_WDRAIN: begin
                if (r_state == S_WALK) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    if (w_last) begin
                        n_state = S_WDRAIN;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_DIVGO;
                end
                if (r_pv) begin
                    w_we_usage  = 1'b1;
                    w_we_prio   = (r_pidx != '0);
                    w_we_status = 1'b1;
                    w_waddr     = r_pidx;
                    w_wusage    = w_new_usage;
                    w_wprio     = w_new_prio;
                    w_wstatus   = w_new_status;
                    if (w_elig) begin
                        if (!r_any || w_new_prio < r_best) begin
                            n_any  = 1'b1;
                            n_best = w_new_prio;
                            n_ties = IW'(1);
                        end else if (w_new_prio == r_best) begin
                            n_ties = r_ties + IW'(1);
                        end
                    end
                end
            end

            S_DIVGO: begin
                if (!r_any) begin
                    n_res_idx = r_cur;
                    n_state   = S_FIN;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end

            S_DIV: begin
                if (w_div_done) begin
                    n_pick  = w_div_rem;
                    n_idx   = IW'(1);
                    n_seen  = '0;
                    n_pv    = 1'b0;
                    n_state = S_SEEK;
                end
            end

            // Find the tied slot whose rank equals the remainder
            S_SEEK, S_SDRAIN: begin
                if (r_state == S_SEEK) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    if (w_last) begin
                        n_state = S_SDRAIN;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_PICK;
                end
                if (r_pv && w_hit) begin
                    if (r_seen == r_pick) begin
                        n_sel   = r_pidx;
                        n_pv    = 1'b0;
                        n_state = S_PICK;
                    end else begin
                        n_seen = r_seen + IW'(1);
                    end
                end
            end

            S_PICK: begin
                n_res_idx = r_sel;
                if (r_sel != r_cur) begin
                    w_we_status = 1'b1;
                    w_waddr     = r_sel;
                    w_wstatus   = ST_RUNNING;
                    n_cur       = r_sel;
                    n_res_sw    = 1'b1;
                end
                n_state = S_FIN;
            end

            // Hand the result to the output register when it is free
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_res_st, r_res_sw, w_idx_ext[OUT_IDX_W-1:0]};
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CW'(1);
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_any       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_any       <= n_any;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rnd      <= n_rnd;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_best     <= n_best;
        r_ties     <= n_ties;
        r_pick     <= n_pick;
        r_seen     <= n_seen;
        r_sel      <= n_sel;
        r_res_idx  <= n_res_idx;
        r_res_sw   <= n_res_sw;
        r_res_st   <= n_res_st;
        r_out_data <= n_out_data;
    end

    // Slot tables: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we_usage) begin
            mem_usage[w_waddr] <= w_wusage;
        end
        if (w_we_prio) begin
            mem_prio[w_waddr] <= w_wprio;
        end
        if (w_we_status) begin
            mem_status[w_waddr] <= w_wstatus;
        end
        r_rd_usage  <= mem_usage[r_idx];
        r_rd_prio   <= mem_prio[r_idx];
        r_rd_status <= mem_status[r_idx];
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
